// ===== rtl/dnsc_pkg.sv =====
// Package for the domain name syntax checker.
// Holds the widths, character codes and the byte class type shared by all rtl files.
// No dependencies.
`timescale 1ns / 1ps

package dnsc_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned LEN_W       = 9;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0] NAME_LIMIT_RESET = 9'd256;
    localparam logic [LEN_W-1:0] COUNT_MAX        = 9'd511;

    localparam logic [CH_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CH_W-1:0] CHAR_0      = 8'h30;
    localparam logic [CH_W-1:0] CHAR_9      = 8'h39;
    localparam logic [CH_W-1:0] CHAR_UC_A   = 8'h41;
    localparam logic [CH_W-1:0] CHAR_UC_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CHAR_LC_A   = 8'h61;
    localparam logic [CH_W-1:0] CHAR_LC_Z   = 8'h7A;

    // class of one item, as the back end needs it
    typedef struct packed {
        logic term;     // terminator item
        logic dot;      // label separator
        logic letter;
        logic digit;
        logic hyphen;
    } byte_class_t;

    // queue status seen by the back end
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_stat_t;

endpackage

// ===== rtl/dnsc_ifs.sv =====
// Handshake interfaces of the domain name syntax checker.
// Name byte stream, validity result and max length write channel.
// Depends on dnsc_pkg.
`timescale 1ns / 1ps

interface dnsc_name_if;
    logic                      valid;
    logic                      ready;
    logic [dnsc_pkg::CH_W-1:0] ch;
    logic                      end_of_name;

    modport source (output valid, output ch, output end_of_name, input ready);
    modport sink   (input valid, input ch, input end_of_name, output ready);
endinterface

interface dnsc_result_if;
    logic valid;
    logic ready;
    logic name_valid;

    modport source (output valid, output name_valid, input ready);
    modport sink   (input valid, input name_valid, output ready);
endinterface

interface dnsc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dnsc_pkg::LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dnsc_front.sv =====
// Front end of the domain name syntax checker.
// Accepts name items and reduces each byte to its class for the queue.
// Depends on dnsc_pkg.
`timescale 1ns / 1ps

module dnsc_front
(
    input  logic [dnsc_pkg::CH_W-1:0] ch,
    input  logic                      end_of_name,
    input  logic                      in_valid,
    input  logic                      queue_full,
    output logic                      in_ready,
    output logic                      push,
    output dnsc_pkg::byte_class_t     push_class
);

    // accept while the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // classify the byte
    always_comb
    begin
        push_class.term   = end_of_name;
        push_class.dot    = (ch == dnsc_pkg::CHAR_DOT);
        push_class.hyphen = (ch == dnsc_pkg::CHAR_HYPHEN);
        push_class.digit  = (ch >= dnsc_pkg::CHAR_0) && (ch <= dnsc_pkg::CHAR_9);
        push_class.letter = ((ch >= dnsc_pkg::CHAR_UC_A) && (ch <= dnsc_pkg::CHAR_UC_Z))
                         || ((ch >= dnsc_pkg::CHAR_LC_A) && (ch <= dnsc_pkg::CHAR_LC_Z));
    end

endmodule

// ===== rtl/dnsc_queue.sv =====
// Short queue between the front and back ends of the syntax checker.
// Holds classified items; push and pop may happen in the same cycle.
// Depends on dnsc_pkg.
`timescale 1ns / 1ps

module dnsc_queue
#(
    parameter int unsigned DEPTH = dnsc_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dnsc_pkg::byte_class_t push_class,
    input  logic                  pop,
    output dnsc_pkg::byte_class_t head,
    output dnsc_pkg::queue_stat_t stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dnsc_pkg::byte_class_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_class;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == CNT_W'(DEPTH));

endmodule

// ===== rtl/dnsc_back.sv =====
// Back end of the domain name syntax checker.
// Applies queued items to the label and name flags and registers the result.
// Depends on dnsc_pkg.
`timescale 1ns / 1ps

module dnsc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dnsc_pkg::LEN_W-1:0] name_limit,
    input  dnsc_pkg::byte_class_t      head,
    input  dnsc_pkg::queue_stat_t      stat,
    output logic                       pop,
    output logic                       out_valid,
    output logic                       out_name_valid,
    input  logic                       out_ready
);

    logic [dnsc_pkg::LEN_W-1:0] byte_count_reg, byte_count_next;
    logic dot_seen_reg, dot_seen_next;
    logic digit_after_dot_reg, digit_after_dot_next;
    logic in_label_reg, in_label_next;
    logic label_bad_reg, label_bad_next;
    logic last_alnum_reg, last_alnum_next;
    logic has_letter_reg, has_letter_next;
    logic name_bad_reg, name_bad_next;
    logic out_valid_reg, out_valid_next;
    logic out_data_reg, out_data_next;

    logic slot_free;
    logic alnum;
    logic label_fails;
    logic name_ok;

    // take an item unless a result is due and the output slot is held
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = stat.not_empty && (!head.term || slot_free);

    assign alnum       = head.letter || head.digit;
    assign label_fails = in_label_reg && (label_bad_reg || !last_alnum_reg || !has_letter_reg);
    assign name_ok     = !(name_bad_reg || label_fails) && dot_seen_reg
                      && !digit_after_dot_reg && (byte_count_reg <= name_limit);

    // update the flags for one item
    always_comb
    begin
        byte_count_next      = byte_count_reg;
        dot_seen_next        = dot_seen_reg;
        digit_after_dot_next = digit_after_dot_reg;
        in_label_next        = in_label_reg;
        label_bad_next       = label_bad_reg;
        last_alnum_next      = last_alnum_reg;
        has_letter_next      = has_letter_reg;
        name_bad_next        = name_bad_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        out_data_next        = out_data_reg;
        if (pop)
        begin
            if (head.term)
            begin
                out_valid_next       = 1'b1;
                out_data_next        = name_ok;
                byte_count_next      = '0;
                dot_seen_next        = 1'b0;
                digit_after_dot_next = 1'b0;
                in_label_next        = 1'b0;
                label_bad_next       = 1'b0;
                last_alnum_next      = 1'b0;
                has_letter_next      = 1'b0;
                name_bad_next        = 1'b0;
            end
            else
            begin
                if (byte_count_reg != dnsc_pkg::COUNT_MAX)
                begin
                    byte_count_next = byte_count_reg + 1'b1;
                end
                if (head.dot)
                begin
                    name_bad_next        = name_bad_reg || label_fails;
                    in_label_next        = 1'b0;
                    label_bad_next       = 1'b0;
                    last_alnum_next      = 1'b0;
                    has_letter_next      = 1'b0;
                    dot_seen_next        = 1'b1;
                    digit_after_dot_next = 1'b0;
                end
                else
                begin
                    in_label_next   = 1'b1;
                    label_bad_next  = (in_label_reg ? label_bad_reg : !alnum)
                                   || (!alnum && !head.hyphen);
                    has_letter_next = (in_label_reg && has_letter_reg) || head.letter;
                    digit_after_dot_next = digit_after_dot_reg || head.digit;
                    last_alnum_next = alnum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            dot_seen_reg        <= 1'b0;
            digit_after_dot_reg <= 1'b0;
            in_label_reg        <= 1'b0;
            label_bad_reg       <= 1'b0;
            last_alnum_reg      <= 1'b0;
            has_letter_reg      <= 1'b0;
            name_bad_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            byte_count_reg      <= byte_count_next;
            dot_seen_reg        <= dot_seen_next;
            digit_after_dot_reg <= digit_after_dot_next;
            in_label_reg        <= in_label_next;
            label_bad_reg       <= label_bad_next;
            last_alnum_reg      <= last_alnum_next;
            has_letter_reg      <= has_letter_next;
            name_bad_reg        <= name_bad_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // hold the result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_name_valid = out_data_reg;

endmodule

// ===== rtl/domain_name_syntax_check_top.sv =====
// Usage notes for domain_name_syntax_check_top.
//
// name_in carries one byte of a domain name per item (ch), and an item with
// end_of_name high closes the name; its ch is ignored. result_out gives one
// item, name_valid, for each closed name and nothing for ordinary bytes.
// cfg writes name_limit (9 bits, reset 256); write it only while idle.
//
// An item is accepted when valid and ready are both high. One item per
// cycle is taken in steady state: the front end classifies a byte into a
// small queue and the back end updates the label flags, one item a cycle.
// An accepted terminator waits in the queue; the back end pops it and
// registers its verdict in the output register that drives result_out.
// When result_out stalls, the back end keeps consuming bytes and stops only
// at the next terminator; once the queue fills, name_in.ready drops.
// Reset clears the queue, all name flags and the output valid flag, and sets
// name_limit to 256. The flags also clear after each terminator.
// Depends on dnsc_pkg, dnsc_ifs, dnsc_front, dnsc_queue and dnsc_back.
`timescale 1ns / 1ps

module domain_name_syntax_check_top
#(
    parameter int unsigned QUEUE_DEPTH = dnsc_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    dnsc_name_if.sink          name_in,
    dnsc_result_if.source      result_out,
    dnsc_cfg_if.sink           cfg
);

    logic [dnsc_pkg::LEN_W-1:0] name_limit_reg;

    logic                  push;
    logic                  pop;
    dnsc_pkg::byte_class_t push_class;
    dnsc_pkg::byte_class_t head;
    dnsc_pkg::queue_stat_t stat;

    // take max length writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg <= dnsc_pkg::NAME_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            name_limit_reg <= cfg.data;
        end
    end

    dnsc_front u_front
    (
        .ch          (name_in.ch),
        .end_of_name (name_in.end_of_name),
        .in_valid    (name_in.valid),
        .queue_full  (stat.full),
        .in_ready    (name_in.ready),
        .push        (push),
        .push_class  (push_class)
    );

    dnsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_class (push_class),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    dnsc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .name_limit     (name_limit_reg),
        .head           (head),
        .stat           (stat),
        .pop            (pop),
        .out_valid      (result_out.valid),
        .out_name_valid (result_out.name_valid),
        .out_ready      (result_out.ready)
    );

`ifndef SYNTHESIS
    // a terminator must not overwrite a result that is still held
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.term && result_out.valid) |-> result_out.ready)
        else $error("terminator popped while result stalled");

    // a new result appears only after a terminator was consumed
    a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !$past(result_out.valid)) |-> $past(pop && head.term))
        else $error("result without terminator");

    // never pop an empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.not_empty)
        else $error("pop from empty queue");

    // a max length write lands in the register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> (name_limit_reg == $past(cfg.data)))
        else $error("max length write lost");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for domain_name_syntax_check_top: streams names, predicts each verdict.
// Directed names, length limits and random names under varying idle and stall patterns.
// Depends on dnsc_pkg, dnsc_ifs and the rtl of domain_name_syntax_check_top.
`timescale 1ns / 1ps

module tb_top;

    localparam int CH_W            = dnsc_pkg::CH_W;
    localparam int LEN_W           = dnsc_pkg::LEN_W;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int HOLD_NAMES      = 12;
    localparam int DRAIN_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 20;

    typedef logic [CH_W-1:0] name_bytes_t[$];

    // Track label flags of the current name and hold the verdicts still owed
    class name_syntax_scoreboard;
        logic [LEN_W-1:0] max_len;
        logic [LEN_W-1:0] byte_count;
        bit               dot_seen;
        bit               digit_tail;
        bit               in_label;
        bit               label_bad;
        bit               last_alnum;
        bit               label_letter;
        bit               name_bad;
        bit               verdicts_due[$];
        int               errors;

        function new();
            max_len = dnsc_pkg::NAME_LIMIT_RESET;
            errors  = 0;
            clear_name();
        endfunction

        function void clear_name();
            byte_count   = '0;
            dot_seen     = 1'b0;
            digit_tail   = 1'b0;
            in_label     = 1'b0;
            label_bad    = 1'b0;
            last_alnum   = 1'b0;
            label_letter = 1'b0;
            name_bad     = 1'b0;
        endfunction

        // Fold the finished label into the name flag, then drop label state
        function void close_label();
            if (in_label && (label_bad || !last_alnum || !label_letter))
                name_bad = 1'b1;
            in_label     = 1'b0;
            label_bad    = 1'b0;
            last_alnum   = 1'b0;
            label_letter = 1'b0;
        endfunction

        // Advance the prediction by one accepted item
        function void take_item(logic [CH_W-1:0] c, logic eon);
            bit letter;
            bit digit;
            bit alnum;
            letter = (c >= dnsc_pkg::CHAR_LC_A && c <= dnsc_pkg::CHAR_LC_Z)
                  || (c >= dnsc_pkg::CHAR_UC_A && c <= dnsc_pkg::CHAR_UC_Z);
            digit  = (c >= dnsc_pkg::CHAR_0 && c <= dnsc_pkg::CHAR_9);
            alnum  = letter || digit;
            if (eon)
            begin
                close_label();
                verdicts_due.push_back(!name_bad && dot_seen && !digit_tail
                                       && byte_count <= max_len);
                clear_name();
            end
            else
            begin
                if (byte_count != dnsc_pkg::COUNT_MAX)
                    byte_count = byte_count + 1'b1;
                if (c == dnsc_pkg::CHAR_DOT)
                begin
                    close_label();
                    dot_seen   = 1'b1;
                    digit_tail = 1'b0;
                end
                else
                begin
                    if (!in_label)
                    begin
                        in_label     = 1'b1;
                        label_bad    = !alnum;
                        label_letter = 1'b0;
                    end
                    if (!alnum && c != dnsc_pkg::CHAR_HYPHEN)
                        label_bad = 1'b1;
                    if (letter)
                        label_letter = 1'b1;
                    if (digit)
                        digit_tail = 1'b1;
                    last_alnum = alnum;
                end
            end
        endfunction

        // Compare one delivered verdict with the oldest owed one
        function void check_verdict(logic got);
            bit owed;
            if (verdicts_due.size() == 0)
            begin
                $error("name_valid: no verdict owed, expected none, actual %0b", got);
                errors++;
            end
            else
            begin
                owed = verdicts_due.pop_front();
                if (got !== owed)
                begin
                    $error("name_valid: expected %0b, actual %0b", owed, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dnsc_name_if   names();
    dnsc_result_if verdicts();
    dnsc_cfg_if    max_len_wr();

    name_syntax_scoreboard sb = new();

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_reqs       = 0;
    int holds_done      = 0;
    int hold_left       = 0;
    int sent_items      = 0;
    int cycle_count     = 0;

    domain_name_syntax_check_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .name_in    (names),
        .result_out (verdicts),
        .cfg        (max_len_wr)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("domain_name_syntax_check_top: mismatch");
        $finish;
    end

    // Monitor both channels, then drive result ready with stalls and hold-offs
    initial
    begin
        verdicts.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (verdicts.valid && verdicts.ready)
                sb.check_verdict(verdicts.name_valid);
            if (names.valid && names.ready)
                sb.take_item(names.ch, names.end_of_name);
            if (holds_done != hold_reqs)
            begin
                holds_done = hold_reqs;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                verdicts.ready <= 1'b0;
            end
            else
                verdicts.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item, idling first at the current rate; return at acceptance
    task automatic send_item(input logic [CH_W-1:0] c, input logic eon);
        bit idle;
        idle = 1'b1;
        while (idle)
        begin
            idle = (sender_idle_pct != 0) && ($urandom_range(99) < sender_idle_pct);
            if (idle)
            begin
                names.valid <= 1'b0;
                @(posedge clk);
            end
        end
        names.valid       <= 1'b1;
        names.ch          <= c;
        names.end_of_name <= eon;
        do
            @(posedge clk);
        while (!names.ready);
        sent_items++;
    endtask

    // Send the bytes of one name and its terminator with a junk byte
    task automatic send_name(input name_bytes_t b);
        foreach (b[i])
            send_item(b[i], 1'b0);
        send_item(CH_W'($urandom()), 1'b1);
    endtask

    task automatic send_text(input string s);
        name_bytes_t b;
        b = {};
        for (int i = 0; i < s.len(); i++)
            b.push_back(s[i]);
        send_name(b);
    endtask

    // Send a name of exactly n bytes; any n above zero gives a well-formed one
    task automatic send_sized(input int n);
        name_bytes_t b;
        b = {};
        if (n == 1)
            b.push_back(dnsc_pkg::CHAR_DOT);
        else if (n >= 2)
        begin
            repeat (n - 2) b.push_back(dnsc_pkg::CHAR_LC_A);
            b.push_back(dnsc_pkg::CHAR_DOT);
            b.push_back(dnsc_pkg::CHAR_LC_A + 8'd1);
        end
        send_name(b);
    endtask

    // Hold the sender low until every owed verdict has arrived
    task automatic wait_drained();
        names.valid <= 1'b0;
        @(posedge clk);
        while (sb.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] v);
        max_len_wr.valid <= 1'b1;
        max_len_wr.data  <= v;
        do
            @(posedge clk);
        while (!max_len_wr.ready);
        max_len_wr.valid <= 1'b0;
        sb.max_len = v;
    endtask

    function automatic logic [CH_W-1:0] rand_alnum(input bit letters_only);
        if (!letters_only && $urandom_range(3) == 0)
            return dnsc_pkg::CHAR_0 + CH_W'($urandom_range(9));
        else if ($urandom_range(1) != 0)
            return dnsc_pkg::CHAR_LC_A + CH_W'($urandom_range(25));
        else
            return dnsc_pkg::CHAR_UC_A + CH_W'($urandom_range(25));
    endfunction

    // Append one label: alnum at both ends, hyphens now and then inside
    function automatic void push_label(ref name_bytes_t b, input bit letters_only);
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if (i != 0 && i != n - 1 && $urandom_range(5) == 0)
                b.push_back(dnsc_pkg::CHAR_HYPHEN);
            else
                b.push_back(rand_alnum(letters_only));
        end
    endfunction

    // Build a name: mostly well-formed, some broken by one edit, some pure noise
    function automatic void random_name(ref name_bytes_t b);
        int kind;
        int labels;
        int pos;
        b    = {};
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            repeat ($urandom_range(12)) b.push_back(CH_W'($urandom()));
        end
        else
        begin
            labels = $urandom_range(1, 4);
            for (int i = 0; i < labels; i++)
            begin
                if (i > 0)
                    b.push_back(dnsc_pkg::CHAR_DOT);
                push_label(b, i == labels - 1 && $urandom_range(9) != 0);
            end
            if (kind < 45)
            begin
                pos = $urandom_range(b.size() - 1);
                case ($urandom_range(6))
                    0: b[pos] = CH_W'($urandom());
                    1: b.push_front(dnsc_pkg::CHAR_DOT);
                    2: b.push_back(dnsc_pkg::CHAR_DOT);
                    3: b.insert(pos, dnsc_pkg::CHAR_DOT);
                    4: b.push_front(dnsc_pkg::CHAR_HYPHEN);
                    5: b.push_back(dnsc_pkg::CHAR_HYPHEN);
                    default: b.insert(pos, CH_W'($urandom_range(128, 255)));
                endcase
            end
        end
    endfunction

    // Main sequence
    initial
    begin
        logic [LEN_W-1:0] settings [8];
        name_bytes_t      b;
        int               lim;
        int               start;

        rst_n              <= 1'b0;
        names.valid        <= 1'b0;
        names.ch           <= '0;
        names.end_of_name  <= 1'b0;
        max_len_wr.valid   <= 1'b0;
        max_len_wr.data    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed names at the reset length limit
        send_text("");
        send_text("ab");
        send_text("a.b");
        send_text("example.com");
        send_text(".com");
        send_text("a..b");
        send_text("a.b.");
        send_text("a.b1");
        send_text("1a.b");
        send_text("123.b");
        send_text("-a.b");
        send_text("a-.b");
        send_text("a-b.c");
        send_text("a_b.c");
        send_text("A.Z");
        send_text("0z.y");
        send_text("z9.Y");
        send_text("a@.b`{");
        send_text(":/[.b");
        send_name('{dnsc_pkg::CHAR_LC_A, 8'h80, dnsc_pkg::CHAR_DOT, dnsc_pkg::CHAR_LC_A});
        send_name('{dnsc_pkg::CHAR_LC_A, 8'hFF, dnsc_pkg::CHAR_DOT, dnsc_pkg::CHAR_LC_A});
        send_name('{dnsc_pkg::CHAR_LC_A, 8'h00, dnsc_pkg::CHAR_DOT, dnsc_pkg::CHAR_LC_A});
        send_sized(257);
        wait_drained();

        // Random phases, each with a length limit and one of four idle and stall patterns
        settings = '{9'd1, 9'd0, 9'd511, 9'd5, 9'd12, 9'd3, 9'd20, 9'd0};
        settings[7] = LEN_W'($urandom_range(1, 24));
        for (int p = 0; p < 8; p++)
        begin
            write_max_len(settings[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            lim = int'(settings[p]);
            if (lim == int'(dnsc_pkg::COUNT_MAX))
                send_sized(530);
            else
                for (int n = lim - 1; n <= lim + 1; n++)
                    if (n >= 0)
                        send_sized(n);
            start = sent_items;
            while (sent_items - start < ITEMS_PER_PHASE)
            begin
                random_name(b);
                send_name(b);
            end
            wait_drained();
        end

        // Back-pressure: hold the result side off while names keep coming
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_reqs++;
        repeat (HOLD_NAMES)
        begin
            random_name(b);
            send_name(b);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.verdicts_due.size() == 0)
            $display("domain_name_syntax_check_top: match");
        else
            $display("domain_name_syntax_check_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dnsc_pkg.sv
rtl/dnsc_ifs.sv
rtl/dnsc_front.sv
rtl/dnsc_queue.sv
rtl/dnsc_back.sv
rtl/domain_name_syntax_check_top.sv
bench/tb_top.sv
